>>> design/cdf_pkg.sv
// shared types, constants and coefficient table for the complex decimating fir
package cdf_pkg;

    localparam int TAPS        = 37;
    localparam int DECIMATION  = 4;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int COEF_FRAC   = COEF_W - 1;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + $clog2(TAPS);
    localparam int TAP_W       = $clog2(TAPS);
    localparam int PHASE_W     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // symmetric low-pass taps, signed Q1.17
    localparam logic signed [COEF_W-1:0] COEF_TABLE [TAPS] = '{
        -18'sd37, -18'sd33, 18'sd46, 18'sd225, 18'sd462, 18'sd630, 18'sd543,
        18'sd33, -18'sd925, -18'sd2113, -18'sd3042, -18'sd3054, -18'sd1530,
        18'sd1847, 18'sd6877, 18'sd12794, 18'sd18411, 18'sd22445, 18'sd23913,
        18'sd22445, 18'sd18411, 18'sd12794, 18'sd6877, 18'sd1847, -18'sd1530,
        -18'sd3054, -18'sd3042, -18'sd2113, -18'sd925, 18'sd33, 18'sd543,
        18'sd630, 18'sd462, 18'sd225, 18'sd46, -18'sd33, -18'sd37
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] inph;
        logic signed [SAMPLE_W-1:0] quad;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_i;
        logic signed [SAMPLE_W-1:0] filtered_q;
    } t_out_beat;

    // one queued job: a sample and whether it closes a decimation phase
    typedef struct packed {
        t_in_beat sample;
        logic     emit;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_FIN
    } t_back_state;

endpackage

>>> design/complex_decimating_fir.sv
// top level of the complex decimating fir
// Complex I/Q low-pass FIR, 37 taps, decimating by four.
// Input channel: i_valid / o_stall carry one I/Q sample beat (i_sample).
// Output channel: o_valid / i_stall carry one filtered I/Q beat (o_result).
// A beat moves at a rising edge where valid is high and stall is low.
// Every fourth accepted input beat produces one output beat; the others
// only enter the delay lines.
// A front end counts the decimation phase and pushes beats into a two-entry
// queue; the back end shifts them into the delay lines and, on a phase end,
// runs one multiply-accumulate per tap per cycle for I and Q together.
// With the back end idle, the fourth input beat passes through queue pop
// and shift, the tap loop, product drain and rounding before o_valid rises.
// Throughput: one non-output beat per cycle; an output beat holds the back
// end until its result is loaded; the serial tap loop sets the throughput.
// Reset (synchronous, active low) clears the delay lines, phase and queue.
// While the receiver stalls, the result holds in the output register, the
// back end holds off its next load, and o_stall rises once the queue fills.
module complex_decimating_fir (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cdf_pkg::t_in_beat  i_sample,
    output logic               o_stall,
    output logic               o_valid,
    output cdf_pkg::t_out_beat o_result,
    input  logic               i_stall
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    cdf_pkg::t_job push_job;
    cdf_pkg::t_job head_job;

    cdf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    cdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    cdf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_stall   (i_stall)
    );

endmodule

>>> design/cdf_front.sv
// front end: accepts input beats and flags each phase-closing beat
module cdf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cdf_pkg::t_in_beat i_sample,
    output logic             o_stall,
    input  logic             i_q_full,
    output logic             o_push,
    output cdf_pkg::t_job    o_job
);

    logic [cdf_pkg::PHASE_W-1:0] r_phase;
    logic [cdf_pkg::PHASE_W-1:0] n_phase;
    logic                        last_phase;

    assign o_stall    = i_q_full;
    assign o_push     = i_valid & ~i_q_full;
    assign last_phase = (r_phase == cdf_pkg::PHASE_W'(cdf_pkg::DECIMATION - 1));

    // job tagging
    always_comb begin
        o_job.sample = i_sample;
        o_job.emit   = last_phase;
    end

    // phase counter
    always_comb begin
        n_phase = r_phase;
        if (o_push) begin
            n_phase = last_phase ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

>>> design/cdf_queue.sv
// short job queue between front and back
module cdf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cdf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cdf_pkg::t_job o_job
);

    cdf_pkg::t_job               r_mem [cdf_pkg::QUEUE_DEPTH];
    logic [cdf_pkg::QPTR_W-1:0]  r_wptr;
    logic [cdf_pkg::QPTR_W-1:0]  r_rptr;
    logic [cdf_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == cdf_pkg::QCNT_W'(cdf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/cdf_back.sv
// back end: delay lines, serial multiply-accumulate, rounding and output register
module cdf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  cdf_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    output cdf_pkg::t_out_beat o_result,
    input  logic               i_stall
);

    cdf_pkg::t_back_state r_state;
    cdf_pkg::t_back_state n_state;

    logic signed [cdf_pkg::SAMPLE_W-1:0] r_line_i [cdf_pkg::TAPS];
    logic signed [cdf_pkg::SAMPLE_W-1:0] r_line_q [cdf_pkg::TAPS];
    logic [cdf_pkg::TAP_W-1:0]           r_tap;
    logic signed [cdf_pkg::PROD_W-1:0]   r_prod_i;
    logic signed [cdf_pkg::PROD_W-1:0]   r_prod_q;
    logic                                r_prod_v;
    logic signed [cdf_pkg::ACC_W-1:0]    r_acc_i;
    logic signed [cdf_pkg::ACC_W-1:0]    r_acc_q;
    logic                                r_out_v;
    cdf_pkg::t_out_beat                  r_out;

    logic last_tap;
    logic out_free;
    logic do_shift;
    logic do_mac;
    logic do_load;
    logic signed [cdf_pkg::COEF_W-1:0] coef_sel;

    assign last_tap = (r_tap == cdf_pkg::TAP_W'(cdf_pkg::TAPS - 1));
    assign out_free = ~r_out_v | ~i_stall;
    assign coef_sel = cdf_pkg::COEF_TABLE[r_tap];
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    // round half up, then clamp to the sample range
    function automatic logic signed [cdf_pkg::SAMPLE_W-1:0] round_sat(
        input logic signed [cdf_pkg::ACC_W-1:0] acc
    );
        logic signed [cdf_pkg::ACC_W-1:0]           rnd;
        logic signed [cdf_pkg::ACC_W-cdf_pkg::COEF_FRAC-1:0] shr;
        logic signed [cdf_pkg::ACC_W-cdf_pkg::COEF_FRAC-1:0] hi;
        logic signed [cdf_pkg::ACC_W-cdf_pkg::COEF_FRAC-1:0] lo;
        rnd = acc + (cdf_pkg::ACC_W'(1) <<< (cdf_pkg::COEF_FRAC - 1));
        shr = rnd[cdf_pkg::ACC_W-1:cdf_pkg::COEF_FRAC];
        hi  = (cdf_pkg::ACC_W-cdf_pkg::COEF_FRAC)'((1 << (cdf_pkg::SAMPLE_W - 1)) - 1);
        lo  = ~hi;
        if (shr > hi) begin
            return hi[cdf_pkg::SAMPLE_W-1:0];
        end else if (shr < lo) begin
            return lo[cdf_pkg::SAMPLE_W-1:0];
        end
        return shr[cdf_pkg::SAMPLE_W-1:0];
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdf_pkg::BK_IDLE: begin
                if (!i_q_empty && i_job.emit) begin
                    n_state = cdf_pkg::BK_MAC;
                end
            end
            cdf_pkg::BK_MAC: begin
                if (last_tap) begin
                    n_state = cdf_pkg::BK_DRAIN;
                end
            end
            cdf_pkg::BK_DRAIN: n_state = cdf_pkg::BK_FIN;
            cdf_pkg::BK_FIN: begin
                if (out_free) begin
                    n_state = cdf_pkg::BK_IDLE;
                end
            end
            default: n_state = cdf_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        do_shift = 1'b0;
        do_mac   = 1'b0;
        do_load  = 1'b0;
        case (r_state)
            cdf_pkg::BK_IDLE:  do_shift = ~i_q_empty;
            cdf_pkg::BK_MAC:   do_mac   = 1'b1;
            cdf_pkg::BK_DRAIN: do_load  = 1'b0;
            cdf_pkg::BK_FIN:   do_load  = out_free;
            default:           do_shift = 1'b0;
        endcase
    end

    assign o_pop = do_shift;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cdf_pkg::BK_IDLE;
            r_tap    <= '0;
            r_prod_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tap    <= do_mac ? (last_tap ? '0 : r_tap + 1'b1) : '0;
            r_prod_v <= do_mac;
            if (do_load) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // delay lines, cleared at reset; during the tap loop they rotate by one
    // per cycle so entry 0 always holds the current tap, and a full loop
    // leaves them where they started
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cdf_pkg::TAPS; k++) begin
                r_line_i[k] <= '0;
                r_line_q[k] <= '0;
            end
        end else if (do_shift) begin
            for (int k = cdf_pkg::TAPS - 1; k > 0; k--) begin
                r_line_i[k] <= r_line_i[k-1];
                r_line_q[k] <= r_line_q[k-1];
            end
            r_line_i[0] <= i_job.sample.inph;
            r_line_q[0] <= i_job.sample.quad;
        end else if (do_mac) begin
            for (int k = 0; k < cdf_pkg::TAPS - 1; k++) begin
                r_line_i[k] <= r_line_i[k+1];
                r_line_q[k] <= r_line_q[k+1];
            end
            r_line_i[cdf_pkg::TAPS-1] <= r_line_i[0];
            r_line_q[cdf_pkg::TAPS-1] <= r_line_q[0];
        end
    end

    // product register, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod_i <= r_line_i[0] * coef_sel;
        r_prod_q <= r_line_q[0] * coef_sel;
        if (do_shift) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_prod_v) begin
            r_acc_i <= r_acc_i + cdf_pkg::ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + cdf_pkg::ACC_W'(r_prod_q);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_out.filtered_i <= round_sat(r_acc_i);
            r_out.filtered_q <= round_sat(r_acc_q);
        end
    end

endmodule

>>> design/cdf_checker.sv
// port-level checker for the complex decimating fir, bound to the top level
module cdf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input cdf_pkg::t_in_beat  i_sample,
    input logic               o_stall,
    input logic               o_valid,
    input cdf_pkg::t_out_beat o_result,
    input logic               i_stall
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    // a stalled result beat keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("output beat changed while stalled");

    // a stalled input beat stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_sample))
        else $error("input beat changed while stalled");

    // reset leaves no result pending
    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // reset empties the queue, so input is open
    a_rst_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind complex_decimating_fir cdf_checker u_cdf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .i_sample (i_sample),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .o_result (o_result),
    .i_stall  (i_stall)
);
